// ===== hdl/krm_pkg.sv =====
// Shared types and constants for the keyed running-mean table.
// Used by krm_fifo, krm_div, krm_engine and keyed_running_mean_table.
`timescale 1ns / 1ps
package krm_pkg;
    localparam int DEFAULT_DEPTH = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int DIV_W         = 24;
    localparam int DIVISOR_W     = 17;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_EMA   = 2'd1;
    localparam logic [1:0] CMD_LIST  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic CFG_WEAK_THR  = 1'b0;
    localparam logic CFG_EMA_ALPHA = 1'b1;

    localparam logic [7:0] WEAK_THR_RESET  = 8'hB5;
    localparam logic [8:0] EMA_ALPHA_RESET = 9'd51;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ap_hash;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [7:0]  rssi;
        logic [7:0]  rssi_spread;
        logic [15:0] count_in;
        logic        weak_in;
        logic [6:0]  max_listed;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic        last;
        logic        listed_valid;
        logic [4:0]  listed_hour;
        logic [2:0]  listed_day;
        logic [7:0]  listed_mean;
        logic [7:0]  listed_spread;
        logic [15:0] listed_samples;
        logic        listed_weak;
        logic [6:0]  entry_total;
        logic [6:0]  weak_total;
    } t_result;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_CMP  = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_EMA2 = 10'b0000010000,
        S_EMAN = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_WR   = 10'b0010000000,
        S_EMIT = 10'b0100000000,
        S_LEND = 10'b1000000000
    } t_state;
endpackage

// ===== hdl/krm_fifo.sv =====
// Small synchronous queue used on the command and result sides.
// Depends on krm_pkg for its default depth.
`timescale 1ns / 1ps
module krm_fifo
    import krm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end
endmodule

// ===== hdl/krm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on krm_pkg for operand widths.
`timescale 1ns / 1ps
module krm_div
    import krm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_W-1:0]     i_dividend,
    input  logic [DIVISOR_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_W-1:0]     o_quot
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]     r_q;
    logic [DIVISOR_W-1:0] r_d;
    logic [DIVISOR_W:0]   r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic [DIVISOR_W:0]   w_sh;
    logic [DIVISOR_W+1:0] w_sub;

    assign w_sh   = {r_rem[DIVISOR_W-1:0], r_q[DIV_W-1]};
    assign w_sub  = {1'b0, w_sh} - {2'b0, r_d};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_sub[DIVISOR_W+1]) begin
                r_rem <= w_sub[DIVISOR_W:0];
                r_q   <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[DIV_W-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== hdl/krm_engine.sv =====
// Back end: table memories, linear search, mean update and result building.
// Depends on krm_pkg and krm_div.
`timescale 1ns / 1ps
module krm_engine
    import krm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    input  logic       i_cmd_empty,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state      r_state;
    t_cmd        r_cmd;
    logic [CW-1:0] r_fill, r_weak_cnt, r_idx;
    logic [6:0]  r_nlist;
    logic [7:0]  r_thr;
    logic [8:0]  r_alpha;
    logic        r_status;
    logic        r_pend_v;
    logic [35:0] r_pend_val;
    logic [4:0]  r_pend_hour;
    logic signed [24:0] r_sum;
    logic signed [7:0]  r_nm;
    logic        r_div_go;

    logic [36:0] r_key_mem [TABLE_DEPTH];
    logic [35:0] r_val_mem [TABLE_DEPTH];
    logic [36:0] r_kq;
    logic [35:0] r_vq;

    logic        w_key_we, w_val_we;
    logic [AW-1:0] w_waddr;
    logic [35:0] w_wval;
    logic [36:0] w_key;
    logic signed [7:0]  w_old;
    logic [15:0] w_cnt, w_cnt_sat;
    logic [9:0]  w_alpha;
    logic        w_new_weak;
    logic        w_div_start, w_div_done;
    logic [DIV_W-1:0] w_div_q, w_mag;
    logic [6:0]  w_fill7, w_weak7;

    assign w_key     = {r_cmd.ap_hash, r_cmd.hour};
    assign w_old     = $signed(r_vq[32:25]);
    assign w_cnt     = r_vq[16:1];
    assign w_cnt_sat = (w_cnt == 16'hFFFF) ? w_cnt : w_cnt + 16'd1;
    assign w_alpha   = (r_alpha > 9'd256) ? 10'd256 : {1'b0, r_alpha};
    assign w_new_weak = (r_nm < $signed(r_thr));
    assign w_mag     = r_sum[24] ? DIV_W'(-r_sum) : r_sum[DIV_W-1:0];
    assign w_fill7   = 7'(r_fill);
    assign w_weak7   = 7'(r_weak_cnt);
    // start in the cycle after S_MUL so the divider sees the fresh sum
    assign w_div_start = r_div_go;

    krm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  ({1'b0, w_cnt} + 17'd1),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    // memory write port
    always_comb begin
        w_key_we = 1'b0;
        w_val_we = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wval   = {r_vq[35:33], r_nm, r_vq[24:17], w_cnt_sat, w_new_weak};
        if (r_state == S_RD && r_idx == r_fill && r_cmd.command != CMD_LIST
            && r_fill != CW'(TABLE_DEPTH)) begin
            w_key_we = 1'b1;
            w_val_we = 1'b1;
            w_waddr  = r_fill[AW-1:0];
            if (r_cmd.command == CMD_ADD) begin
                w_wval = {r_cmd.weekday, r_cmd.rssi, r_cmd.rssi_spread,
                          r_cmd.count_in, r_cmd.weak_in};
            end else begin
                w_wval = {3'd0, r_cmd.rssi, 8'd0, 16'd1,
                          ($signed(r_cmd.rssi) < $signed(r_thr))};
            end
        end else if (r_state == S_WR) begin
            w_val_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_waddr] <= w_key;
        end
        if (w_val_we) begin
            r_val_mem[w_waddr] <= w_wval;
        end
        if (r_state == S_RD) begin
            r_kq <= r_key_mem[r_idx[AW-1:0]];
            r_vq <= r_val_mem[r_idx[AW-1:0]];
        end
    end

    // result builder
    always_comb begin
        o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.entry_total = w_fill7;
        o_res.weak_total  = w_weak7;
        unique case (r_state)
            S_EMIT: begin
                o_res_push  = !i_res_full;
                o_res.status = r_status;
                o_res.last   = 1'b1;
            end
            S_CMP: begin
                if (r_cmd.command == CMD_LIST && r_kq[36:5] == r_cmd.ap_hash
                    && r_pend_v) begin
                    o_res_push = !i_res_full;
                end
            end
            S_LEND: begin
                o_res_push = !i_res_full;
                o_res.last = 1'b1;
            end
            default: ;
        endcase
        if (r_state != S_EMIT && r_pend_v) begin
            o_res.listed_valid   = 1'b1;
            o_res.listed_hour    = r_pend_hour;
            o_res.listed_day     = r_pend_val[35:33];
            o_res.listed_mean    = r_pend_val[32:25];
            o_res.listed_spread  = r_pend_val[24:17];
            o_res.listed_samples = r_pend_val[16:1];
            o_res.listed_weak    = r_pend_val[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_weak_cnt <= '0;
            r_idx      <= '0;
            r_nlist    <= '0;
            r_pend_v   <= 1'b0;
            r_status   <= 1'b0;
            r_div_go   <= 1'b0;
            r_thr      <= WEAK_THR_RESET;
            r_alpha    <= EMA_ALPHA_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WEAK_THR) begin
                    r_thr <= i_cfg_data[7:0];
                end else begin
                    r_alpha <= i_cfg_data;
                end
            end
            r_div_go <= (r_state == S_MUL) && (r_cmd.command == CMD_ADD);
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd    <= i_cmd;
                        r_idx    <= '0;
                        r_nlist  <= '0;
                        r_pend_v <= 1'b0;
                        r_status <= 1'b0;
                        if (i_cmd.command == CMD_CLEAR) begin
                            r_fill     <= '0;
                            r_weak_cnt <= '0;
                            r_state    <= S_EMIT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_cmd.command == CMD_LIST) begin
                        r_state <= (r_idx == r_fill || r_nlist == r_cmd.max_listed)
                                   ? S_LEND : S_CMP;
                    end else if (r_idx == r_fill) begin
                        r_state <= S_EMIT;
                        if (r_fill == CW'(TABLE_DEPTH)) begin
                            r_status <= 1'b1;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                            r_weak_cnt <= r_weak_cnt + CW'(w_wval[0]);
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_cmd.command == CMD_LIST) begin
                        if (r_kq[36:5] == r_cmd.ap_hash) begin
                            if (!(r_pend_v && i_res_full)) begin
                                r_pend_v    <= 1'b1;
                                r_pend_val  <= r_vq;
                                r_pend_hour <= r_kq[4:0];
                                r_nlist     <= r_nlist + 7'd1;
                                r_idx       <= r_idx + 1'b1;
                                r_state     <= S_RD;
                            end
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end
                    end else if (r_kq == w_key) begin
                        r_state <= S_MUL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_MUL: begin
                    if (r_cmd.command == CMD_ADD) begin
                        r_sum   <= w_old * $signed({1'b0, w_cnt})
                                   + 25'($signed(r_cmd.rssi));
                        r_state <= S_DIV;
                    end else begin
                        r_sum   <= 25'($signed(w_alpha) * $signed(r_cmd.rssi));
                        r_state <= S_EMA2;
                    end
                end
                S_EMA2: begin
                    r_sum   <= r_sum + 25'($signed(10'd256 - w_alpha) * w_old);
                    r_state <= S_EMAN;
                end
                S_EMAN: begin
                    r_nm    <= r_sum[24] ? 8'(-(w_mag >> 8)) : 8'(w_mag >> 8);
                    r_state <= S_WR;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_nm    <= r_sum[24] ? 8'(-w_div_q) : 8'(w_div_q);
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_weak_cnt <= r_weak_cnt - CW'(r_vq[0]) + CW'(w_new_weak);
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LEND: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count above table depth");
    a_weak_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_weak_cnt <= r_fill)
        else $error("weak count above fill count");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_cmd_empty && i_cmd.command == CMD_CLEAR)
        |=> (r_fill == '0 && r_weak_cnt == '0))
        else $error("clear did not empty the table");
    a_list_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_cmd.command == CMD_LIST)
        |-> r_nlist <= r_cmd.max_listed)
        else $error("list emitted past its limit");
`endif
endmodule

// ===== hdl/keyed_running_mean_table.sv =====
// Top level of the keyed running-mean table: command queue, engine, result queue.
// Depends on krm_pkg, krm_fifo and krm_engine.
`timescale 1ns / 1ps
// Commands enter through a two-entry queue and results leave through another,
// so either side may stall. Add and EMA search the table linearly, each stored
// entry taking one registered memory read (S_RD) and one compare (S_CMP); a
// matching add then runs the serial divider (S_MUL, S_DIV, S_WR), and an EMA
// update goes through S_MUL, S_EMA2, S_EMAN and S_WR. A list scans entries the
// same way; clear empties the table at once. The default table has 64 entries.
module keyed_running_mean_table
    import krm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_ap_hash,
    input  logic [4:0]  i_hour,
    input  logic [2:0]  i_weekday,
    input  logic signed [7:0] i_rssi,
    input  logic [7:0]  i_rssi_spread,
    input  logic [15:0] i_count_in,
    input  logic        i_weak_in,
    input  logic [6:0]  i_max_listed,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic        o_last,
    output logic        o_listed_valid,
    output logic [4:0]  o_listed_hour,
    output logic [2:0]  o_listed_day,
    output logic signed [7:0] o_listed_mean,
    output logic [7:0]  o_listed_spread,
    output logic [15:0] o_listed_samples,
    output logic        o_listed_weak,
    output logic [6:0]  o_entry_total,
    output logic [6:0]  o_weak_total
);
    t_cmd    w_cmd_in, w_cmd;
    t_result w_res_in, w_res;
    logic    w_cmd_empty, w_cmd_pop, w_res_full, w_res_push;

    assign w_cmd_in = '{command: i_command, ap_hash: i_ap_hash, hour: i_hour,
                        weekday: i_weekday, rssi: i_rssi,
                        rssi_spread: i_rssi_spread, count_in: i_count_in,
                        weak_in: i_weak_in, max_listed: i_max_listed};

    krm_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_empty (w_cmd_empty),
        .o_data  (w_cmd)
    );

    krm_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    krm_fifo #(.WIDTH($bits(t_result)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res)
    );

    assign o_status         = w_res.status;
    assign o_last           = w_res.last;
    assign o_listed_valid   = w_res.listed_valid;
    assign o_listed_hour    = w_res.listed_hour;
    assign o_listed_day     = w_res.listed_day;
    assign o_listed_mean    = w_res.listed_mean;
    assign o_listed_spread  = w_res.listed_spread;
    assign o_listed_samples = w_res.listed_samples;
    assign o_listed_weak    = w_res.listed_weak;
    assign o_entry_total    = w_res.entry_total;
    assign o_weak_total     = w_res.weak_total;
endmodule
